FILE: hdl/fftag_pkg.sv
// ----------------------------------------------------------------------------
// fftag_pkg: shared types and constants for the boundary-tag allocator
// Holds the sequencer states, status codes, request kinds and field widths.
// ----------------------------------------------------------------------------
package fftag_pkg;

  localparam int SIZE_W     = 12;  // byte count of an allocate request
  localparam int INDEX_W    = 9;   // payload word index on the ports
  localparam int STATUS_W   = 2;
  localparam int NEED_W     = 10;  // words needed, at most 512 from 12-bit bytes
  localparam int WORD_BYTES = 8;
  localparam int WORD_SHIFT = 3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BADPTR  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AWALK,
    S_ASPLIT,
    S_FWALK,
    S_FNEXT,
    S_FPREV,
    S_SETPREV,
    S_RESP
  } state_e;

endpackage

FILE: hdl/first_fit_boundary_tag_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit: first-fit heap allocator
// Walks a header store of boundary tags to allocate and free heap chunks.
// ----------------------------------------------------------------------------
// A zero-size allocate answers in the cycle after acceptance. An allocate that
// fits walks, then S_ASPLIT (on a split), S_SETPREV, S_RESP; a free walks, then
// S_FNEXT, S_FPREV (on a merge with the previous chunk), S_SETPREV, S_RESP, and
// a failed walk goes to S_RESP. Throughput: one word at a time; busy_o drops
// in the cycle after the strobe. Reset: a clearing pass over every word rebuilds
// the headers, busy_o high. The result strobe cannot be stalled by the receiver.
module first_fit_boundary_tag_allocator_unit #(
  parameter int HEAP_WORDS = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            kind_i,
  input  logic [fftag_pkg::SIZE_W-1:0]    size_bytes_i,
  input  logic [fftag_pkg::INDEX_W-1:0]   payload_index_i,
  output logic                            done_o,
  output logic [fftag_pkg::STATUS_W-1:0]  status_o,
  output logic [fftag_pkg::INDEX_W-1:0]   result_index_o
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int IW = (AW + 1 > fftag_pkg::NEED_W) ? AW + 1 : fftag_pkg::NEED_W;
  localparam int DW = 2 * AW + 2;
  localparam logic [IW-1:0] HW_I      = IW'(HEAP_WORDS);
  localparam logic [IW-1:0] ONE_I     = IW'(1);
  localparam logic [IW-1:0] TWO_I     = IW'(2);
  localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_WORDS - 2);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_WORDS - 1);

  fftag_pkg::state_e  state_q, state_d;
  fftag_pkg::status_e status_q, status_d;

  logic [AW-1:0]                   clr_q, clr_d;
  logic [IW-1:0]                   p_q, p_d;
  logic [IW-1:0]                   n_q, n_d;
  logic [fftag_pkg::NEED_W-1:0]    need_q, need_d;
  logic [fftag_pkg::INDEX_W-1:0]   idx_q, idx_d;
  logic [DW-1:0]                   hdr_q, hdr_d;
  logic [IW-1:0]                   h_q, h_d;
  logic [IW-1:0]                   nx_q, nx_d;
  logic [IW-1:0]                   sq_q, sq_d;
  logic [AW-1:0]                   pp_q, pp_d;
  logic [IW-1:0]                   tgt_q, tgt_d;
  logic [AW-1:0]                   psz_q, psz_d;
  logic                            pused_q, pused_d;
  logic [fftag_pkg::INDEX_W-1:0]   res_q, res_d;

  // Header RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // Fields of the header just read
  logic          rd_used, rd_pused;
  logic [AW-1:0] rd_size, rd_psize;
  logic [IW-1:0] rd_size_i;

  // Walk and update arithmetic
  logic                          accept;
  logic [fftag_pkg::SIZE_W:0]    bytes_rnd;
  logic [fftag_pkg::NEED_W-1:0]  need_in;
  logic [IW-1:0]                 need_i, p_next, extra, q_pos;
  logic                          chunk_ok, fit, split, found;
  logic                          next_free, prev_free;
  logic [IW-1:0]                 cs_i, ps_i, ns_i, tot, tgt_free, pp_pos;

  assign accept    = start_i && !busy_o;
  assign bytes_rnd = {1'b0, size_bytes_i} + (fftag_pkg::SIZE_W + 1)'(fftag_pkg::WORD_BYTES - 1);
  assign need_in   = fftag_pkg::NEED_W'(bytes_rnd >> fftag_pkg::WORD_SHIFT);

  assign rd_used   = ram_rdata[DW-1];
  assign rd_size   = ram_rdata[DW-2:AW+1];
  assign rd_pused  = ram_rdata[AW];
  assign rd_psize  = ram_rdata[AW-1:0];
  assign rd_size_i = IW'(rd_size);

  assign need_i   = IW'(need_q);
  assign p_next   = p_q + ONE_I + rd_size_i;
  assign chunk_ok = (rd_size != '0) && (n_q < HW_I);
  assign fit      = !rd_used && (rd_size_i >= need_i);
  assign extra    = rd_size_i - need_i;
  assign split    = extra >= TWO_I;
  assign q_pos    = p_q + ONE_I + need_i;
  assign found    = rd_used && (p_q + ONE_I == IW'(idx_q));

  // Free: hdr_q holds the chunk being freed, the RAM output its successor.
  assign cs_i      = IW'(hdr_q[DW-2:AW+1]);
  assign ps_i      = IW'(hdr_q[AW-1:0]);
  assign next_free = (nx_q < HW_I) && (rd_size != '0) && !rd_used;
  assign prev_free = !hdr_q[AW] && (ps_i != '0) && (h_q >= ps_i + ONE_I);
  assign ns_i      = next_free ? rd_size_i : '0;
  assign tot       = cs_i + (prev_free ? ps_i + ONE_I : '0) + (next_free ? ns_i + ONE_I : '0);
  assign tgt_free  = next_free ? nx_q + ONE_I + ns_i : nx_q;
  assign pp_pos    = h_q - ONE_I - ps_i;

  fftag_ram #(
    .WIDTH (DW),
    .DEPTH (HEAP_WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fftag_pkg::S_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = fftag_pkg::S_IDLE;
      end
      fftag_pkg::S_IDLE: begin
        if (accept) begin
          if (kind_i == fftag_pkg::KIND_FREE) begin
            state_d = fftag_pkg::S_FWALK;
          end else if (size_bytes_i == '0) begin
            state_d = fftag_pkg::S_RESP;
          end else begin
            state_d = fftag_pkg::S_AWALK;
          end
        end
      end
      fftag_pkg::S_AWALK: begin
        if (!chunk_ok) begin
          state_d = fftag_pkg::S_RESP;
        end else if (fit) begin
          state_d = split ? fftag_pkg::S_ASPLIT : fftag_pkg::S_SETPREV;
        end else if (p_next >= HW_I) begin
          state_d = fftag_pkg::S_RESP;
        end
      end
      fftag_pkg::S_ASPLIT: state_d = fftag_pkg::S_SETPREV;
      fftag_pkg::S_FWALK: begin
        if (!chunk_ok) begin
          state_d = fftag_pkg::S_RESP;
        end else if (found) begin
          state_d = fftag_pkg::S_FNEXT;
        end else if (p_next >= HW_I) begin
          state_d = fftag_pkg::S_RESP;
        end
      end
      fftag_pkg::S_FNEXT: begin
        state_d = prev_free ? fftag_pkg::S_FPREV : fftag_pkg::S_SETPREV;
      end
      fftag_pkg::S_FPREV:   state_d = fftag_pkg::S_SETPREV;
      fftag_pkg::S_SETPREV: state_d = fftag_pkg::S_RESP;
      fftag_pkg::S_RESP:    state_d = fftag_pkg::S_IDLE;
      default:              state_d = fftag_pkg::S_IDLE;
    endcase
  end

  // Datapath and header RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    clr_d     = clr_q;
    p_d       = p_q;
    n_d       = n_q;
    need_d    = need_q;
    idx_d     = idx_q;
    hdr_d     = hdr_q;
    h_d       = h_q;
    nx_d      = nx_q;
    sq_d      = sq_q;
    pp_d      = pp_q;
    tgt_d     = tgt_q;
    psz_d     = psz_q;
    pused_d   = pused_q;
    status_d  = status_q;
    res_d     = res_q;

    unique case (state_q)
      fftag_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? {1'b0, INIT_SIZE, 1'b1, {AW{1'b0}}} : '0;
        clr_d     = clr_q + AW'(1);
      end
      fftag_pkg::S_IDLE: begin
        if (accept) begin
          p_d      = '0;
          n_d      = '0;
          need_d   = need_in;
          idx_d    = payload_index_i;
          res_d    = '0;
          status_d = fftag_pkg::ST_OK;
          ram_re   = 1'b1;
          if (kind_i == fftag_pkg::KIND_ALLOC && size_bytes_i == '0) begin
            status_d = fftag_pkg::ST_ZERO;
          end
        end
      end
      fftag_pkg::S_AWALK: begin
        if (!chunk_ok) begin
          status_d = fftag_pkg::ST_NOSPACE;
        end else if (fit) begin
          res_d     = fftag_pkg::INDEX_W'(p_q + ONE_I);
          ram_we    = 1'b1;
          ram_waddr = p_q[AW-1:0];
          tgt_d     = p_next;
          ram_re    = p_next < HW_I;
          ram_raddr = p_next[AW-1:0];
          if (split) begin
            // Hand out the front, leave the rest as a new free chunk.
            ram_wdata = {1'b1, AW'(need_q), rd_pused, rd_psize};
            sq_d      = q_pos;
            psz_d     = AW'(extra - ONE_I);
            pused_d   = 1'b0;
          end else begin
            ram_wdata = {1'b1, rd_size, rd_pused, rd_psize};
            psz_d     = rd_size;
            pused_d   = 1'b1;
          end
        end else begin
          p_d       = p_next;
          n_d       = n_q + ONE_I;
          ram_re    = p_next < HW_I;
          ram_raddr = p_next[AW-1:0];
          if (p_next >= HW_I) status_d = fftag_pkg::ST_NOSPACE;
        end
      end
      fftag_pkg::S_ASPLIT: begin
        ram_we    = sq_q < HW_I;
        ram_waddr = sq_q[AW-1:0];
        ram_wdata = {1'b0, psz_q, 1'b1, AW'(need_q)};
      end
      fftag_pkg::S_FWALK: begin
        if (!chunk_ok) begin
          status_d = fftag_pkg::ST_BADPTR;
        end else if (found) begin
          hdr_d     = ram_rdata;
          h_d       = p_q;
          nx_d      = p_next;
          ram_re    = p_next < HW_I;
          ram_raddr = p_next[AW-1:0];
        end else begin
          p_d       = p_next;
          n_d       = n_q + ONE_I;
          ram_re    = p_next < HW_I;
          ram_raddr = p_next[AW-1:0];
          if (p_next >= HW_I) status_d = fftag_pkg::ST_BADPTR;
        end
      end
      fftag_pkg::S_FNEXT: begin
        tgt_d   = tgt_free;
        psz_d   = AW'(tot);
        pused_d = 1'b0;
        pp_d    = pp_pos[AW-1:0];
        if (prev_free) begin
          // The merged chunk starts at the previous header: fetch it first.
          ram_re    = 1'b1;
          ram_raddr = pp_pos[AW-1:0];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = h_q[AW-1:0];
          ram_wdata = {1'b0, AW'(tot), hdr_q[AW], hdr_q[AW-1:0]};
          ram_re    = tgt_free < HW_I;
          ram_raddr = tgt_free[AW-1:0];
        end
      end
      fftag_pkg::S_FPREV: begin
        ram_we    = 1'b1;
        ram_waddr = pp_q;
        ram_wdata = {1'b0, psz_q, rd_pused, rd_psize};
        ram_re    = tgt_q < HW_I;
        ram_raddr = tgt_q[AW-1:0];
      end
      fftag_pkg::S_SETPREV: begin
        // Only a word that starts a chunk takes the new previous-chunk fields.
        ram_we    = (tgt_q < HW_I) && (rd_size != '0);
        ram_waddr = tgt_q[AW-1:0];
        ram_wdata = {rd_used, rd_size, pused_q, psz_q};
      end
      fftag_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fftag_pkg::S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    n_q      <= n_d;
    need_q   <= need_d;
    idx_q    <= idx_d;
    hdr_q    <= hdr_d;
    h_q      <= h_d;
    nx_q     <= nx_d;
    sq_q     <= sq_d;
    pp_q     <= pp_d;
    tgt_q    <= tgt_d;
    psz_q    <= psz_d;
    pused_q  <= pused_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  // Outputs
  assign busy_o         = state_q != fftag_pkg::S_IDLE;
  assign done_o         = state_q == fftag_pkg::S_RESP;
  assign status_o       = status_q;
  assign result_index_o = res_q;

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("result strobe not followed by idle");

  a_index_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != fftag_pkg::ST_OK) |-> result_index_o == '0)
    else $error("non-zero index on a failed request");

  a_zero_size_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == fftag_pkg::KIND_ALLOC && size_bytes_i == '0)
      |=> (done_o && status_o == fftag_pkg::ST_ZERO))
    else $error("zero-size allocate not answered at once");

  a_write_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy_o)
    else $error("header store written while idle");

endmodule

FILE: hdl/fftag_ram.sv
// ----------------------------------------------------------------------------
// fftag_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and holds
// its value while the read enable is low.
// ----------------------------------------------------------------------------
module fftag_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: test/first_fit_boundary_tag_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_unit_test: self-checking bench for the allocator
// Drives allocate and free requests through the start/busy handshake. A
// behavioural copy of the header store predicts every status and index. A
// short table of directed requests opens the run: zero sizes, overlong sizes,
// tight fits, double frees and every kind of merge. Random fill and drain
// sessions then follow, with sender gaps varied across the run.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_WORDS = 512;
  localparam int RANDOM_REQUESTS = 500;

  typedef struct packed {
    logic [fftag_pkg::NEED_W-1:0] size;
    logic                         used;
    logic [fftag_pkg::NEED_W-1:0] prior_size;
    logic                         prior_used;
  } tag_t;

  typedef struct packed {
    fftag_pkg::status_e                status;
    logic [fftag_pkg::INDEX_W-1:0]     index;
  } reply_t;

  typedef struct packed {
    logic                          kind;
    logic [fftag_pkg::SIZE_W-1:0]  size;
    logic [fftag_pkg::INDEX_W-1:0] index;
    logic                          typed;
    fftag_pkg::status_e            status;
    logic [fftag_pkg::INDEX_W-1:0] result;
  } row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           kind_i = fftag_pkg::KIND_ALLOC;
  logic [fftag_pkg::SIZE_W-1:0]   size_bytes_i = '0;
  logic [fftag_pkg::INDEX_W-1:0]  payload_index_i = '0;
  logic                           busy_o;
  logic                           done_o;
  logic [fftag_pkg::STATUS_W-1:0] status_o;
  logic [fftag_pkg::INDEX_W-1:0]  result_index_o;

  tag_t   heap_tags [HEAP_WORDS];
  reply_t pending_replies [$];
  int     live_payloads [$];
  int     freed_payloads [$];
  int     mismatch_count = 0;
  int     issued_count = 0;

  // Typed rows can be read off by hand; the others rely on the predictor.
  row_t opening_rows [25] = '{
    '{fftag_pkg::KIND_ALLOC, 12'd0,    9'd0,   1'b1, fftag_pkg::ST_ZERO,    9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd1,   1'b1, fftag_pkg::ST_BADPTR,  9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd1,    9'd0,   1'b1, fftag_pkg::ST_OK,      9'd1},
    '{fftag_pkg::KIND_ALLOC, 12'd8,    9'd0,   1'b1, fftag_pkg::ST_OK,      9'd3},
    '{fftag_pkg::KIND_ALLOC, 12'd9,    9'd0,   1'b1, fftag_pkg::ST_OK,      9'd5},
    '{fftag_pkg::KIND_ALLOC, 12'd4095, 9'd0,   1'b1, fftag_pkg::ST_NOSPACE, 9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd3,   1'b1, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd3,   1'b1, fftag_pkg::ST_BADPTR,  9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd5,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd1,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd4080, 9'd0,   1'b1, fftag_pkg::ST_OK,      9'd1},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd0,   1'b1, fftag_pkg::ST_BADPTR,  9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd511, 1'b1, fftag_pkg::ST_BADPTR,  9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd1,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd4072, 9'd0,   1'b1, fftag_pkg::ST_OK,      9'd1},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd1,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd4064, 9'd0,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd8,    9'd0,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd510, 1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd1,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd2048, 9'd0,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd2048, 9'd0,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_ALLOC, 12'd2024, 9'd0,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd1,   1'b0, fftag_pkg::ST_OK,      9'd0},
    '{fftag_pkg::KIND_FREE,  12'd0,    9'd258, 1'b0, fftag_pkg::ST_OK,      9'd0}
  };

  first_fit_boundary_tag_allocator_unit #(
    .HEAP_WORDS(HEAP_WORDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .size_bytes_i   (size_bytes_i),
    .payload_index_i(payload_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_index_o (result_index_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit tag_present(int i);
    return i < HEAP_WORDS && heap_tags[i].size != 0;
  endfunction

  function automatic void write_tag(int i, int sz, logic used);
    if (i < HEAP_WORDS) begin
      heap_tags[i].size = fftag_pkg::NEED_W'(sz);
      heap_tags[i].used = used;
    end
  endfunction

  function automatic void mark_prev(int i, int sz, logic used);
    if (tag_present(i)) begin
      heap_tags[i].prior_size = fftag_pkg::NEED_W'(sz);
      heap_tags[i].prior_used = used;
    end
  endfunction

  // Applies one request to the header store and returns the answer it earns.
  function automatic reply_t heap_apply(logic kind, logic [fftag_pkg::SIZE_W-1:0] size,
                                        logic [fftag_pkg::INDEX_W-1:0] index);
    reply_t r;
    int need, p, n, c, extra, q, cs, nx, ps, ns, pp, total;
    bit found, prev_free, next_free;
    r.status = fftag_pkg::ST_OK;
    r.index = '0;
    if (kind == fftag_pkg::KIND_ALLOC) begin
      if (size == '0) begin
        r.status = fftag_pkg::ST_ZERO;
        return r;
      end
      need = (int'(size) + fftag_pkg::WORD_BYTES - 1) / fftag_pkg::WORD_BYTES;
      p = 0;
      n = 0;
      while (tag_present(p) && n < HEAP_WORDS) begin
        c = int'(heap_tags[p].size);
        if (!heap_tags[p].used && c >= need) begin
          extra = c - need;
          if (extra >= 2) begin
            q = p + 1 + need;
            write_tag(p, need, 1'b1);
            if (q < HEAP_WORDS) begin
              heap_tags[q].size = fftag_pkg::NEED_W'(extra - 1);
              heap_tags[q].used = 1'b0;
              heap_tags[q].prior_size = fftag_pkg::NEED_W'(need);
              heap_tags[q].prior_used = 1'b1;
            end
            mark_prev(q + extra, extra - 1, 1'b0);
          end else begin
            // A leftover too small for a header goes out with the chunk.
            write_tag(p, c, 1'b1);
            mark_prev(p + 1 + c, c, 1'b1);
          end
          r.index = fftag_pkg::INDEX_W'(p + 1);
          return r;
        end
        p += 1 + c;
        n++;
      end
      r.status = fftag_pkg::ST_NOSPACE;
      return r;
    end

    found = 1'b0;
    p = 0;
    n = 0;
    while (tag_present(p) && n < HEAP_WORDS && !found) begin
      if (heap_tags[p].used && p + 1 == int'(index)) begin
        found = 1'b1;
      end else begin
        p += 1 + int'(heap_tags[p].size);
        n++;
      end
    end
    if (!found) begin
      r.status = fftag_pkg::ST_BADPTR;
      return r;
    end
    cs = int'(heap_tags[p].size);
    nx = p + 1 + cs;
    ps = int'(heap_tags[p].prior_size);
    prev_free = !heap_tags[p].prior_used && ps != 0 && p >= 1 + ps;
    next_free = tag_present(nx) && !heap_tags[nx].used;
    ns = next_free ? int'(heap_tags[nx].size) : 0;
    pp = prev_free ? p - 1 - ps : p;
    if (prev_free && next_free) begin
      total = ps + 1 + cs + 1 + ns;
      write_tag(pp, total, 1'b0);
      mark_prev(nx + 1 + ns, total, 1'b0);
    end else if (prev_free) begin
      total = ps + 1 + cs;
      write_tag(pp, total, 1'b0);
      mark_prev(nx, total, 1'b0);
    end else if (next_free) begin
      total = cs + 1 + ns;
      write_tag(p, total, 1'b0);
      mark_prev(nx + 1 + ns, total, 1'b0);
    end else begin
      write_tag(p, cs, 1'b0);
      mark_prev(nx, cs, 1'b0);
    end
    return r;
  endfunction

  task automatic issue_request(input logic kind, input logic [fftag_pkg::SIZE_W-1:0] size,
                               input logic [fftag_pkg::INDEX_W-1:0] index,
                               input logic typed, input reply_t typed_reply);
    int idle_pct [4] = '{0, 55, 0, 12};
    int gap;
    bit hold;
    reply_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct[(issued_count / 100) % 4] && gap < 40) gap++;
    hold = (issued_count == 150) || ($urandom_range(63) == 0);
    if (gap > 0 || (hold && pending_replies.size() != 0)) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (hold && pending_replies.size() != 0) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= kind;
    size_bytes_i <= size;
    payload_index_i <= index;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    issued_count++;
    predicted = heap_apply(kind, size, index);
    pending_replies.push_back(typed ? typed_reply : predicted);
    if (predicted.status == fftag_pkg::ST_OK) begin
      if (kind == fftag_pkg::KIND_ALLOC) begin
        live_payloads.push_back(int'(predicted.index));
      end else begin
        foreach (live_payloads[i]) begin
          if (live_payloads[i] == int'(index)) begin
            live_payloads.delete(i);
            break;
          end
        end
        freed_payloads.push_back(int'(index));
        if (freed_payloads.size() > 32) void'(freed_payloads.pop_front());
      end
    end
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word, status %0d index %0d", $time, status_o,
                 result_index_o);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (result_index_o !== want.index) begin
          $display("%0t: result_index expected %0d, got %0d", $time, want.index,
                   result_index_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int choice;
    bit filling;
    reply_t no_reply;
    no_reply = '{fftag_pkg::ST_OK, '0};
    filling = 1'b1;
    foreach (heap_tags[i]) heap_tags[i] = '0;
    heap_tags[0].size = fftag_pkg::NEED_W'(HEAP_WORDS - 2);
    heap_tags[0].prior_used = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) begin
      issue_request(opening_rows[i].kind, opening_rows[i].size, opening_rows[i].index,
                    opening_rows[i].typed,
                    '{opening_rows[i].status, opening_rows[i].result});
    end

    // Fill and drain sessions keep the heap cycling between crowded and
    // empty, so that no-space answers and every kind of merge turn up.
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k % 40 == 0) filling = ($urandom_range(1) == 0);
      choice = $urandom_range(99);
      if (choice < 8) begin
        case ($urandom_range(3))
          0: issue_request(fftag_pkg::KIND_ALLOC, '0,
                           fftag_pkg::INDEX_W'($urandom_range(511)), 1'b0, no_reply);
          1: issue_request(fftag_pkg::KIND_FREE, fftag_pkg::SIZE_W'($urandom_range(4095)),
                           fftag_pkg::INDEX_W'($urandom_range(511)), 1'b0, no_reply);
          2: begin
            if (freed_payloads.size() != 0) begin
              issue_request(fftag_pkg::KIND_FREE, fftag_pkg::SIZE_W'($urandom_range(4095)),
                            fftag_pkg::INDEX_W'(
                              freed_payloads[$urandom_range(freed_payloads.size() - 1)]),
                            1'b0, no_reply);
            end else begin
              issue_request(fftag_pkg::KIND_FREE, '0,
                            fftag_pkg::INDEX_W'($urandom_range(511)), 1'b0, no_reply);
            end
          end
          default: issue_request(fftag_pkg::KIND_ALLOC,
                                 fftag_pkg::SIZE_W'($urandom_range(4095)),
                                 fftag_pkg::INDEX_W'($urandom_range(511)), 1'b0, no_reply);
        endcase
      end else if (live_payloads.size() != 0 &&
                   $urandom_range(99) < (filling ? 25 : 80)) begin
        issue_request(fftag_pkg::KIND_FREE, fftag_pkg::SIZE_W'($urandom_range(4095)),
                      fftag_pkg::INDEX_W'(
                        live_payloads[$urandom_range(live_payloads.size() - 1)]),
                      1'b0, no_reply);
      end else begin
        choice = $urandom_range(99);
        issue_request(fftag_pkg::KIND_ALLOC,
                      fftag_pkg::SIZE_W'(choice < 70 ? $urandom_range(64, 1) :
                                         choice < 90 ? $urandom_range(512, 65) :
                                                       $urandom_range(4095, 1)),
                      fftag_pkg::INDEX_W'($urandom_range(511)), 1'b0, no_reply);
      end
    end

    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
